### rtl/dss_pkg.sv
// ----------------------------------------------------------------------------
// dss_pkg
// Shared constants for the diffusion stencil step: command codes, register
// indexes, register reset values and the result queue depth.
// ----------------------------------------------------------------------------
`default_nettype none

package dss_pkg;

  // Stream command carried in tuser
  localparam logic CMD_DRAIN = 1'b1;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned DIM_W      = 11;
  localparam int unsigned ALPHA_W    = 16;
  localparam int unsigned FRAC_BITS  = 16;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA     = 2'd2;

  localparam logic [DIM_W-1:0]   GRID_ROWS_RST = 11'd1024;
  localparam logic [DIM_W-1:0]   GRID_COLS_RST = 11'd1024;
  localparam logic [ALPHA_W-1:0] ALPHA_RST     = 16'd6554;

  // Result queue behind the arithmetic pipeline
  localparam int unsigned FIFO_DEPTH = 8;

endpackage

`default_nettype wire

### rtl/diffusion_stencil_step.sv
// ----------------------------------------------------------------------------
// diffusion_stencil_step
// One explicit five-point heat-equation step over a grid streamed in raster
// order, with two-row line stores and a registered arithmetic pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one word per item: tuser = 0 sends the next grid sample
//   (tdata), tuser = 1 asks for one pending result once the grid is in.
//   m_axis returns new cell values in raster order, tlast on the final cell.
//   cfg writes grid_rows (0), grid_cols (1) and alpha (2); any such write
//   restarts the grid. Write only while the block is idle.
// Throughput: one item per cycle while s_axis_tready is high. Each sample
//   does one line-store write and two reads per row bank, and one multiply;
//   nothing iterates. Path: a result passes the input register/store read,
//   laplacian, multiply, add and saturate with the new-row store read, then
//   the result queue.
// Output m appears with sample m + 2*cols + 1; the last 2*cols + 1 results
//   come out on drain items.
// Reset: positions and queue clear, registers take 1024 x 1024 and alpha
//   6554. The line stores are not cleared; they are read only after written.
// Stall: an 8-word result queue keeps taking items while m_axis is held;
//   s_axis_tready drops only when 8 results are queued or in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module diffusion_stencil_step #(
  parameter int unsigned MAX_COLS    = 1024,
  parameter int unsigned MAX_ROWS    = 1024,
  parameter int unsigned SAMPLE_BITS = 32
) (
  input  wire logic                                        clk,
  input  wire logic                                        rst,
  // tdata: sample [SAMPLE_BITS-1:0], zero padded to whole bytes
  input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]            s_axis_tdata,
  // tuser: command [0]
  input  wire logic                                        s_axis_tuser,
  input  wire logic                                        s_axis_tvalid,
  output logic                                             s_axis_tready,
  // tdata: value [SAMPLE_BITS-1:0], zero padded to whole bytes
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]                 m_axis_tdata,
  output logic                                             m_axis_tlast,
  output logic                                             m_axis_tvalid,
  input  wire logic                                        m_axis_tready,
  input  wire logic                                        cfg_valid,
  output logic                                             cfg_ready,
  input  wire logic [dss_pkg::CFG_IDX_W-1:0]               cfg_index,
  input  wire logic [dss_pkg::CFG_DATA_W-1:0]              cfg_data
);

  import dss_pkg::*;

  localparam int unsigned SB  = SAMPLE_BITS;
  localparam int unsigned TDW = ((SAMPLE_BITS+7)/8)*8;
  localparam int unsigned CW  = $clog2(MAX_COLS);
  localparam int unsigned CNW = $clog2(MAX_COLS+1);
  localparam int unsigned RNW = $clog2(MAX_ROWS+1);
  localparam int unsigned LW  = $clog2(2*MAX_COLS+2);
  localparam int unsigned NAW = $clog2(2*MAX_COLS);
  localparam int unsigned PW  = $clog2(FIFO_DEPTH);
  localparam int unsigned QW  = $clog2(FIFO_DEPTH+1);
  localparam int unsigned LPW = SB + 3;
  localparam int unsigned MW  = LPW + ALPHA_W + 1;
  localparam int unsigned DW  = MW - FRAC_BITS;
  localparam int unsigned XW  = DW + 1;

  typedef struct packed {
    logic           comp;
    logic           emit;
    logic           last;
    logic [NAW-1:0] naddr;
    logic [NAW-1:0] eaddr;
  } ctl_t;

  // Configuration registers
  logic [DIM_W-1:0]   grid_rows;
  logic [DIM_W-1:0]   grid_cols;
  logic [ALPHA_W-1:0] alpha;
  logic [RNW-1:0]     rows_e;
  logic [CNW-1:0]     cols_e;
  logic               cfg_wr;
  logic               cfg_restart;

  // Stream position
  logic [RNW-1:0] in_row, in_row_next;
  logic [CW-1:0]  in_col, in_col_next, in_col_p1;
  logic [RNW-1:0] out_row, out_row_next;
  logic [CW-1:0]  out_col, out_col_next;
  logic [LW-1:0]  lag, lag_next;

  logic           acc, is_drain, grid_done, take_s, emit0, last0, comp0;
  logic [RNW-1:0] sr;
  logic [CW-1:0]  sc;
  logic [SB-1:0]  sample_in;
  ctl_t           ctl0;

  // Line stores, one bank per row parity
  logic [SB-1:0] in_mem0 [MAX_COLS];
  logic [SB-1:0] in_mem1 [MAX_COLS];
  logic [SB-1:0] new_mem [2*MAX_COLS];
  logic [SB-1:0] rd0a, rd0b, rd1a, rd1b;

  // Pipeline
  ctl_t                  p1_ctl, p2_ctl, p3_ctl;
  logic                  p1_samp, p1_bank;
  logic [SB-1:0]         p1_s;
  logic signed [SB-1:0]  wreg;
  logic signed [SB-1:0]  nb_n, nb_c, nb_e;
  logic signed [LPW-1:0] lap;
  logic signed [LPW-1:0] p2_lap;
  logic signed [SB-1:0]  p2_c, p3_c;
  logic signed [MW-1:0]  prod;
  logic signed [DW-1:0]  p3_delta;
  logic signed [XW-1:0]  sum;
  logic [SB-1:0]         nv;
  logic                  p4_emit, p4_last;
  logic [SB-1:0]         p4_val;

  // Result queue
  logic [SB-1:0] q_val  [FIFO_DEPTH];
  logic          q_last [FIFO_DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [QW-1:0] fill, credit;
  logic          pop;

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid & cfg_ready;
  assign cfg_restart = cfg_wr && (cfg_index == REG_GRID_ROWS ||
                                  cfg_index == REG_GRID_COLS ||
                                  cfg_index == REG_ALPHA);

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows <= GRID_ROWS_RST;
      grid_cols <= GRID_COLS_RST;
      alpha     <= ALPHA_RST;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        REG_GRID_ROWS: grid_rows <= cfg_data[DIM_W-1:0];
        REG_GRID_COLS: grid_cols <= cfg_data[DIM_W-1:0];
        REG_ALPHA:     alpha     <= cfg_data[ALPHA_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (grid_rows < DIM_W'(3))              rows_e = RNW'(3);
    else if (32'(grid_rows) > MAX_ROWS)     rows_e = RNW'(MAX_ROWS);
    else                                    rows_e = RNW'(grid_rows);
    if (grid_cols < DIM_W'(3))              cols_e = CNW'(3);
    else if (32'(grid_cols) > MAX_COLS)     cols_e = CNW'(MAX_COLS);
    else                                    cols_e = CNW'(grid_cols);
  end

  // --------------------------------------------------------------------------
  // Input side: positions, emit decision, store addresses
  // --------------------------------------------------------------------------
  assign s_axis_tready = (credit != QW'(FIFO_DEPTH));
  assign acc       = s_axis_tvalid & s_axis_tready;
  assign is_drain  = (s_axis_tuser == CMD_DRAIN);
  assign sample_in = s_axis_tdata[SB-1:0];
  assign grid_done = (in_row >= rows_e);
  assign take_s    = acc & ~is_drain & ~grid_done;
  assign emit0     = acc & (is_drain ? grid_done
                                     : (~grid_done && lag >= LW'({cols_e, 1'b1})));
  assign last0     = (out_row == rows_e - RNW'(1)) && (CNW'(out_col) == cols_e - CNW'(1));
  assign comp0     = (in_row >= RNW'(2)) && (in_col != '0) &&
                     ((CNW+1)'(in_col) + (CNW+1)'(2) <= (CNW+1)'(cols_e));
  assign in_col_p1 = (32'(in_col) == MAX_COLS - 1) ? in_col : in_col + CW'(1);

  always_comb begin
    // clamp the output position to the interior cell it copies
    if (out_row == '0)                      sr = RNW'(1);
    else if (out_row > rows_e - RNW'(2))    sr = rows_e - RNW'(2);
    else                                    sr = out_row;
    if (out_col == '0)                      sc = CW'(1);
    else if (CNW'(out_col) > cols_e - CNW'(2)) sc = CW'(cols_e - CNW'(2));
    else                                    sc = out_col;
  end

  always_comb begin
    ctl0.comp  = take_s & comp0;
    ctl0.emit  = emit0;
    ctl0.last  = last0;
    ctl0.naddr = (in_row[0] ? NAW'(0) : NAW'(MAX_COLS)) + NAW'(in_col);
    ctl0.eaddr = (sr[0] ? NAW'(MAX_COLS) : NAW'(0)) + NAW'(sc);
  end

  always_comb begin
    in_row_next  = in_row;
    in_col_next  = in_col;
    out_row_next = out_row;
    out_col_next = out_col;
    lag_next     = lag;
    if (take_s) begin
      lag_next = lag_next + LW'(1);
      if (CNW'(in_col) == cols_e - CNW'(1)) begin
        in_col_next = '0;
        in_row_next = in_row + RNW'(1);
      end else begin
        in_col_next = in_col + CW'(1);
      end
    end
    if (emit0) begin
      lag_next = lag_next - LW'(1);
      if (CNW'(out_col) == cols_e - CNW'(1)) begin
        out_col_next = '0;
        out_row_next = out_row + RNW'(1);
      end else begin
        out_col_next = out_col + CW'(1);
      end
    end
    if (cfg_restart || (emit0 && last0)) begin
      in_row_next  = '0;
      in_col_next  = '0;
      out_row_next = '0;
      out_col_next = '0;
      lag_next     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_row  <= '0;
      in_col  <= '0;
      out_row <= '0;
      out_col <= '0;
      lag     <= '0;
    end else begin
      in_row  <= in_row_next;
      in_col  <= in_col_next;
      out_row <= out_row_next;
      out_col <= out_col_next;
      lag     <= lag_next;
    end
  end

  // Input line stores: write the current column, read it and the next one
  always_ff @(posedge clk) begin
    if (take_s && !in_row[0]) in_mem0[in_col] <= sample_in;
    rd0a <= in_mem0[in_col];
    rd0b <= in_mem0[in_col_p1];
  end

  always_ff @(posedge clk) begin
    if (take_s && in_row[0]) in_mem1[in_col] <= sample_in;
    rd1a <= in_mem1[in_col];
    rd1b <= in_mem1[in_col_p1];
  end

  // --------------------------------------------------------------------------
  // Stage 1: laplacian
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_ctl  <= '0;
      p1_samp <= 1'b0;
    end else begin
      p1_ctl  <= ctl0;
      p1_samp <= take_s;
    end
    p1_s    <= sample_in;
    p1_bank <= in_row[0];
  end

  // north is two rows up in the current bank; west, center, east one row up
  assign nb_n = p1_bank ? $signed(rd1a) : $signed(rd0a);
  assign nb_c = p1_bank ? $signed(rd0a) : $signed(rd1a);
  assign nb_e = p1_bank ? $signed(rd0b) : $signed(rd1b);

  assign lap = LPW'(nb_n) + LPW'($signed(p1_s)) + LPW'(wreg) + LPW'(nb_e)
             - (LPW'(nb_c) <<< 2);

  always_ff @(posedge clk) begin
    // hold the center as the next column's west neighbor
    if (p1_samp) wreg <= nb_c;
  end

  // --------------------------------------------------------------------------
  // Stage 2: scale by alpha, floor shift by the fraction
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) p2_ctl <= '0;
    else     p2_ctl <= p1_ctl;
    p2_lap <= lap;
    p2_c   <= nb_c;
  end

  assign prod = MW'(p2_lap) * MW'($signed({1'b0, alpha}));

  // --------------------------------------------------------------------------
  // Stage 3: add, saturate, write new row; read the cell to send
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) p3_ctl <= '0;
    else     p3_ctl <= p2_ctl;
    p3_delta <= prod[MW-1:FRAC_BITS];
    p3_c     <= p2_c;
  end

  assign sum = XW'(p3_c) + XW'(p3_delta);

  always_comb begin
    if ((&sum[XW-1:SB-1]) || !(|sum[XW-1:SB-1])) nv = sum[SB-1:0];
    else if (sum[XW-1])                           nv = {1'b1, {(SB-1){1'b0}}};
    else                                          nv = {1'b0, {(SB-1){1'b1}}};
  end

  always_ff @(posedge clk) begin
    if (p3_ctl.comp) new_mem[p3_ctl.naddr] <= nv;
    // forward a value written by this same item
    if (p3_ctl.comp && p3_ctl.naddr == p3_ctl.eaddr) p4_val <= nv;
    else                                             p4_val <= new_mem[p3_ctl.eaddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p4_emit <= 1'b0;
      p4_last <= 1'b0;
    end else begin
      p4_emit <= p3_ctl.emit;
      p4_last <= p3_ctl.last;
    end
  end

  // --------------------------------------------------------------------------
  // Result queue; credit counts results queued or still in the pipeline
  // --------------------------------------------------------------------------
  assign pop = m_axis_tvalid & m_axis_tready;

  always_ff @(posedge clk) begin
    if (p4_emit) begin
      q_val[wr_ptr]  <= p4_val;
      q_last[wr_ptr] <= p4_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
      credit <= '0;
    end else begin
      if (p4_emit) wr_ptr <= (32'(wr_ptr) == FIFO_DEPTH - 1) ? '0 : wr_ptr + PW'(1);
      if (pop)     rd_ptr <= (32'(rd_ptr) == FIFO_DEPTH - 1) ? '0 : rd_ptr + PW'(1);
      fill   <= fill + QW'(p4_emit) - QW'(pop);
      credit <= credit + QW'(emit0) - QW'(pop);
    end
  end

  assign m_axis_tvalid = (fill != '0);
  assign m_axis_tdata  = TDW'(q_val[rd_ptr]);
  assign m_axis_tlast  = q_last[rd_ptr];

endmodule

`default_nettype wire
